/* sv/cmap_format4_glyph_lookup_macros.svh */
// Assertion macros for the cmap format-4 glyph lookup.
`ifndef CMAP_FORMAT4_GLYPH_LOOKUP_MACROS_SVH
`define CMAP_FORMAT4_GLYPH_LOOKUP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CMAP4_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CMAP4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CMAP4_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CMAP4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/cmap4_pkg.sv */
package cmap4_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int GLYPH_WORDS_DEF  = 4096;
  localparam int CNT_W            = 9;
  localparam int IDX_W            = 19;

  typedef logic [1:0] req_t;

  localparam req_t REQ_SEG    = 2'd0;
  localparam req_t REQ_GLYPH  = 2'd1;
  localparam req_t REQ_LOOKUP = 2'd2;

  typedef struct packed {
    logic [15:0] end_code;
    logic [15:0] start_code;
    logic [15:0] id_delta;
    logic [15:0] range_offset;
  } seg_entry_t;

endpackage

/* sv/cmap4_req_if.sv */
interface cmap4_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [11:0]        entry_index;
  logic [15:0]        end_code;
  logic [15:0]        start_code;
  logic signed [15:0] id_delta;
  logic [15:0]        range_offset;
  logic [15:0]        glyph_word;
  logic [15:0]        char_code;

  modport source (
    output valid, req_type, entry_index, end_code, start_code, id_delta,
           range_offset, glyph_word, char_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, end_code, start_code, id_delta,
           range_offset, glyph_word, char_code,
    output ready
  );
endinterface

/* sv/cmap4_res_if.sv */
interface cmap4_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph_id;
  logic        mapped;

  modport source (output valid, glyph_id, mapped, input ready);
  modport sink (input valid, glyph_id, mapped, output ready);
endinterface

/* sv/cmap4_store.sv */
module cmap4_store #(
  parameter int MAX_SEGMENTS      = cmap4_pkg::MAX_SEGMENTS_DEF,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::GLYPH_WORDS_DEF,
  localparam int SEG_AW = $clog2(MAX_SEGMENTS),
  localparam int GW_AW  = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1
) (
  input  logic                   clk,
  input  logic                   seg_we,
  input  logic [SEG_AW-1:0]      seg_waddr,
  input  cmap4_pkg::seg_entry_t  seg_wdata,
  input  logic [SEG_AW-1:0]      seg_raddr,
  output cmap4_pkg::seg_entry_t  seg_rdata,
  input  logic                   gly_we,
  input  logic [GW_AW-1:0]       gly_waddr,
  input  logic [15:0]            gly_wdata,
  input  logic [GW_AW-1:0]       gly_raddr,
  output logic [15:0]            gly_rdata
);

  cmap4_pkg::seg_entry_t seg_mem [MAX_SEGMENTS];
  logic [15:0]           gly_mem [GLYPH_ARRAY_WORDS];

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rdata <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (gly_we) begin
      gly_mem[gly_waddr] <= gly_wdata;
    end
    gly_rdata <= gly_mem[gly_raddr];
  end

endmodule

/* sv/cmap4_seq.sv */
module cmap4_seq #(
  parameter int MAX_SEGMENTS      = cmap4_pkg::MAX_SEGMENTS_DEF,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::GLYPH_WORDS_DEF,
  localparam int SEG_AW = $clog2(MAX_SEGMENTS),
  localparam int GW_AW  = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cmap4_pkg::CNT_W-1:0]  seg_count,
  cmap4_req_if.sink                    in_req,
  cmap4_res_if.source                  out_res,
  output logic                         seg_we,
  output logic [SEG_AW-1:0]            seg_waddr,
  output cmap4_pkg::seg_entry_t        seg_wdata,
  output logic [SEG_AW-1:0]            seg_raddr,
  input  cmap4_pkg::seg_entry_t        seg_rdata,
  output logic                         gly_we,
  output logic [GW_AW-1:0]             gly_waddr,
  output logic [15:0]                  gly_wdata,
  output logic [GW_AW-1:0]             gly_raddr,
  input  logic [15:0]                  gly_rdata
);

  localparam int CW = cmap4_pkg::CNT_W;
  localparam int IW = cmap4_pkg::IDX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_SEG   = 3'd3;
  localparam logic [2:0] ST_IDX   = 3'd4;
  localparam logic [2:0] ST_GLY   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_glyph_r, out_glyph_nxt;
  logic          out_mapped_r, out_mapped_nxt;
  logic [15:0]   code_r, code_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [15:0]   delta_r, delta_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   res_glyph_r, res_glyph_nxt;
  logic          res_hit_r, res_hit_nxt;

  logic          accept;
  logic [CW-1:0] n_comb;
  logic [CW-1:0] new_lo, new_hi;
  logic [CW:0]   bound_sum;
  logic [15:0]   code_diff;
  logic          idx_ok;

  assign accept    = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  assign out_res.valid    = out_valid_r;
  assign out_res.glyph_id = out_glyph_r;
  assign out_res.mapped   = out_mapped_r;

  assign seg_we    = accept && (in_req.req_type == cmap4_pkg::REQ_SEG) &&
                     (32'(in_req.entry_index) < 32'(MAX_SEGMENTS));
  assign seg_waddr = SEG_AW'(in_req.entry_index);
  assign seg_wdata = '{end_code:     in_req.end_code,
                       start_code:   in_req.start_code,
                       id_delta:     $unsigned(in_req.id_delta),
                       range_offset: in_req.range_offset};
  assign gly_we    = accept && (in_req.req_type == cmap4_pkg::REQ_GLYPH) &&
                     (32'(in_req.entry_index) < 32'(GLYPH_ARRAY_WORDS));
  assign gly_waddr = GW_AW'(in_req.entry_index);
  assign gly_wdata = in_req.glyph_word;
  assign gly_raddr = GW_AW'(idx_r);

  assign n_comb    = (32'(seg_count) > 32'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS) : seg_count;
  assign code_diff = code_r - seg_rdata.start_code;
  assign idx_ok    = !idx_r[IW-1] && (idx_r < IW'(GLYPH_ARRAY_WORDS));

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_glyph_nxt  = out_glyph_r;
    out_mapped_nxt = out_mapped_r;
    code_nxt       = code_r;
    n_nxt          = n_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    delta_nxt      = delta_r;
    idx_nxt        = idx_r;
    res_glyph_nxt  = res_glyph_r;
    res_hit_nxt    = res_hit_r;
    seg_raddr      = SEG_AW'(mid_r);
    new_lo         = lo_r;
    new_hi         = hi_r;
    bound_sum      = {1'b0, lo_r} + {1'b0, hi_r};

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req.req_type == cmap4_pkg::REQ_LOOKUP)) begin
          code_nxt = in_req.char_code;
          n_nxt    = n_comb;
          lo_nxt   = '0;
          hi_nxt   = n_comb;
          if (n_comb < CW'(2)) begin
            res_glyph_nxt = '0;
            res_hit_nxt   = 1'b0;
            state_nxt     = ST_FIN;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        mid_nxt   = bound_sum[CW:1];
        seg_raddr = SEG_AW'(mid_nxt);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (seg_rdata.end_code < code_r) begin
          new_lo = mid_r + CW'(1);
          new_hi = hi_r;
        end else begin
          new_lo = lo_r;
          new_hi = mid_r;
        end
        lo_nxt    = new_lo;
        hi_nxt    = new_hi;
        bound_sum = {1'b0, new_lo} + {1'b0, new_hi};
        if (new_lo < new_hi) begin
          mid_nxt   = bound_sum[CW:1];
          seg_raddr = SEG_AW'(mid_nxt);
        end else begin
          seg_raddr = SEG_AW'(new_lo);
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        delta_nxt = seg_rdata.id_delta;
        idx_nxt   = IW'(seg_rdata.range_offset[15:1]) + IW'(code_diff) +
                    IW'(lo_r) - IW'(n_r);
        if ((lo_r >= n_r - CW'(1)) || (seg_rdata.start_code > code_r)) begin
          res_glyph_nxt = '0;
          res_hit_nxt   = 1'b0;
          state_nxt     = ST_FIN;
        end else if (seg_rdata.range_offset == 16'd0) begin
          res_glyph_nxt = code_r + seg_rdata.id_delta;
          res_hit_nxt   = 1'b1;
          state_nxt     = ST_FIN;
        end else begin
          res_hit_nxt = 1'b1;
          state_nxt   = ST_IDX;
        end
      end
      ST_IDX: begin
        if (idx_ok) begin
          state_nxt = ST_GLY;
        end else begin
          res_glyph_nxt = '0;
          state_nxt     = ST_FIN;
        end
      end
      ST_GLY: begin
        res_glyph_nxt = (gly_rdata != 16'd0) ? gly_rdata + delta_r : 16'd0;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_glyph_nxt  = res_glyph_r;
          out_mapped_nxt = res_hit_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_glyph_r  <= out_glyph_nxt;
    out_mapped_r <= out_mapped_nxt;
    code_r       <= code_nxt;
    n_r          <= n_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    delta_r      <= delta_nxt;
    idx_r        <= idx_nxt;
    res_glyph_r  <= res_glyph_nxt;
    res_hit_r    <= res_hit_nxt;
  end

endmodule

/* sv/cmap_format4_glyph_lookup.sv */
// Segment and glyph-word writes produce no result. A lookup runs a binary search
// with one segment-memory read per step, then one segment read and, for a matching
// segment with a nonzero range offset and an in-range index, one glyph-word read.
// Synchronous reset clears the sequencer and output valid and sets segment_count
// to 1; both memories keep their contents and need no clearing pass.
`include "cmap_format4_glyph_lookup_macros.svh"

module cmap_format4_glyph_lookup #(
  parameter int MAX_SEGMENTS      = cmap4_pkg::MAX_SEGMENTS_DEF,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::GLYPH_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cmap4_pkg::CNT_W-1:0]  cfg_wdata,
  cmap4_req_if.sink                    in_req,
  cmap4_res_if.source                  out_res
);

  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int GW_AW  = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1;

  logic [cmap4_pkg::CNT_W-1:0] seg_count_r;

  logic                  seg_we;
  logic [SEG_AW-1:0]     seg_waddr;
  cmap4_pkg::seg_entry_t seg_wdata;
  logic [SEG_AW-1:0]     seg_raddr;
  cmap4_pkg::seg_entry_t seg_rdata;
  logic                  gly_we;
  logic [GW_AW-1:0]      gly_waddr;
  logic [15:0]           gly_wdata;
  logic [GW_AW-1:0]      gly_raddr;
  logic [15:0]           gly_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= cmap4_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      seg_count_r <= cfg_wdata;
    end
  end

  cmap4_seq #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .GLYPH_ARRAY_WORDS (GLYPH_ARRAY_WORDS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_count (seg_count_r),
    .in_req    (in_req),
    .out_res   (out_res),
    .seg_we    (seg_we),
    .seg_waddr (seg_waddr),
    .seg_wdata (seg_wdata),
    .seg_raddr (seg_raddr),
    .seg_rdata (seg_rdata),
    .gly_we    (gly_we),
    .gly_waddr (gly_waddr),
    .gly_wdata (gly_wdata),
    .gly_raddr (gly_raddr),
    .gly_rdata (gly_rdata)
  );

  cmap4_store #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .GLYPH_ARRAY_WORDS (GLYPH_ARRAY_WORDS)
  ) u_store (
    .clk       (clk),
    .seg_we    (seg_we),
    .seg_waddr (seg_waddr),
    .seg_wdata (seg_wdata),
    .seg_raddr (seg_raddr),
    .seg_rdata (seg_rdata),
    .gly_we    (gly_we),
    .gly_waddr (gly_waddr),
    .gly_wdata (gly_wdata),
    .gly_raddr (gly_raddr),
    .gly_rdata (gly_rdata)
  );

  `CMAP4_ASSERT_NEXT(a_write_no_result, clk, rst_n, in_req.valid && in_req.ready && in_req.req_type != cmap4_pkg::REQ_LOOKUP && !out_res.valid, !out_res.valid, "write transaction produced a result")
  `CMAP4_ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_req.valid && in_req.ready && in_req.req_type == cmap4_pkg::REQ_LOOKUP, !in_req.ready, "input taken while a lookup is in progress")
  `CMAP4_ASSERT_IMPLY(a_result_from_busy, clk, rst_n, $rose(out_res.valid), !$past(in_req.ready), "result appeared without a lookup in progress")

endmodule

/* verif/testbench.sv */
module testbench;

  localparam cmap4_pkg::req_t REQ_SEG    = cmap4_pkg::REQ_SEG;
  localparam cmap4_pkg::req_t REQ_GLYPH  = cmap4_pkg::REQ_GLYPH;
  localparam cmap4_pkg::req_t REQ_LOOKUP = cmap4_pkg::REQ_LOOKUP;
  localparam cmap4_pkg::req_t REQ_NONE   = 2'd3;
  localparam int SEG_DEPTH = 256;
  localparam int WORD_DEPTH = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 106;
  localparam int PHASE_LOOKUPS = 60;
  localparam logic [8:0] PHASE_COUNTS [9] = '{
    9'd2, 9'd256, 9'd0, 9'd9, 9'd511, 9'd1, 9'd3, 9'd40, 9'd6
  };

  typedef struct packed {
    cmap4_pkg::req_t kind;
    logic [11:0]     index;
    logic [15:0]     end_c;
    logic [15:0]     start_c;
    logic [15:0]     delta;
    logic [15:0]     offset;
    logic [15:0]     word;
    logic [15:0]     code;
  } request_t;

  typedef struct packed {
    logic [15:0] glyph_id;
    logic        mapped;
  } result_t;

  typedef struct packed {
    bit         is_cfg;
    logic [8:0] cfg_value;
    request_t   req;
    bit         typed;
    result_t    res;
  } script_row_t;

  localparam script_row_t SCRIPT [23] = '{
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000},
      1'b1, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_NONE, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'h000, 16'h0010, 16'h0000, 16'hFFFF, 16'h0000, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'h001, 16'h0021, 16'h0020, 16'h7FFF, 16'h0008, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'h002, 16'h4000, 16'h0030, 16'h0000, 16'hFFFF, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'h003, 16'h8000, 16'h7000, 16'h0005, 16'h0001, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'h004, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_SEG, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_GLYPH, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_GLYPH, 12'h001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8002, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_GLYPH, 12'hFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0005},
      1'b1, '{16'h0000, 1'b0}},
    '{1'b1, 9'd5, '{REQ_NONE, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
      1'b0, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000},
      1'b1, '{16'hFFFF, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0010},
      1'b1, '{16'h000F, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0011},
      1'b1, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0020},
      1'b1, '{16'h0000, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0021},
      1'b1, '{16'h0001, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0022},
      1'b1, '{16'h0000, 1'b0}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0030},
      1'b1, '{16'h0000, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7000},
      1'b1, '{16'h0000, 1'b1}},
    '{1'b0, 9'd0, '{REQ_LOOKUP, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF},
      1'b1, '{16'h0000, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [cmap4_pkg::CNT_W-1:0] cfg_wdata;

  cmap4_req_if in_req();
  cmap4_res_if out_res();

  cmap_format4_glyph_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_res   (out_res)
  );

  logic [15:0] end_mem    [SEG_DEPTH];
  logic [15:0] start_mem  [SEG_DEPTH];
  logic [15:0] delta_mem  [SEG_DEPTH];
  logic [15:0] offset_mem [SEG_DEPTH];
  logic [15:0] word_mem   [WORD_DEPTH];
  bit          seg_loaded [SEG_DEPTH];
  bit          word_loaded[WORD_DEPTH];
  int unsigned seg_count = 1;

  result_t glyph_queue[$];
  int      sent_count = 0;
  int      lookups_sent = 0;
  int      mapped_seen = 0;
  int      settings_seen = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int segments_in_use();
    return (seg_count > SEG_DEPTH) ? SEG_DEPTH : int'(seg_count);
  endfunction

  // Also reports the first segment or glyph word the lookup would read before it was loaded.
  function automatic void glyph_for_code(input logic [15:0] code, output result_t res,
                                         output int missing_seg, output int missing_word);
    int     n;
    int     lo;
    int     hi;
    int     mid;
    int     s;
    longint idx;
    res = '0;
    missing_seg = -1;
    missing_word = -1;
    n = segments_in_use();
    if (n < 2) return;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (!seg_loaded[mid]) begin
        missing_seg = mid;
        return;
      end
      if (end_mem[mid] < code) lo = mid + 1;
      else hi = mid;
    end
    s = lo;
    if (s >= n - 1) return;
    if (!seg_loaded[s]) begin
      missing_seg = s;
      return;
    end
    if (start_mem[s] > code) return;
    res.mapped = 1'b1;
    if (offset_mem[s] == 16'h0000) begin
      res.glyph_id = code + delta_mem[s];
      return;
    end
    idx = longint'(offset_mem[s] / 2) + longint'(code) - longint'(start_mem[s]) + s - n;
    if (idx < 0 || idx >= WORD_DEPTH) return;
    if (!word_loaded[idx]) begin
      missing_word = int'(idx);
      return;
    end
    if (word_mem[idx] != 16'h0000) res.glyph_id = word_mem[idx] + delta_mem[s];
  endfunction

  function automatic request_t scrambled_request();
    request_t r;
    r.kind    = cmap4_pkg::req_t'($urandom_range(0, 3));
    r.index   = 12'($urandom);
    r.end_c   = 16'($urandom);
    r.start_c = 16'($urandom);
    r.delta   = 16'($urandom);
    r.offset  = 16'($urandom);
    r.word    = 16'($urandom);
    r.code    = 16'($urandom);
    return r;
  endfunction

  task automatic send_request(input request_t r, input bit typed = 1'b0,
                              input result_t typed_res = '0);
    result_t predicted;
    int      ms;
    int      mw;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.req_type     <= r.kind;
    in_req.entry_index  <= r.index;
    in_req.end_code     <= r.end_c;
    in_req.start_code   <= r.start_c;
    in_req.id_delta     <= r.delta;
    in_req.range_offset <= r.offset;
    in_req.glyph_word   <= r.word;
    in_req.char_code    <= r.code;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent_count++;
    case (r.kind)
      REQ_SEG: begin
        if (r.index < SEG_DEPTH) begin
          end_mem[r.index]    = r.end_c;
          start_mem[r.index]  = r.start_c;
          delta_mem[r.index]  = r.delta;
          offset_mem[r.index] = r.offset;
          seg_loaded[r.index] = 1'b1;
        end
      end
      REQ_GLYPH: begin
        word_mem[r.index]    = r.word;
        word_loaded[r.index] = 1'b1;
      end
      REQ_LOOKUP: begin
        glyph_for_code(r.code, predicted, ms, mw);
        if (typed) predicted = typed_res;
        if (predicted.mapped) mapped_seen++;
        lookups_sent++;
        glyph_queue.push_back(predicted);
      end
      default: begin
      end
    endcase
  endtask

  // Loads whatever the lookup would otherwise read unloaded, then sends it.
  task automatic lookup_code(input logic [15:0] code);
    result_t  res;
    int       ms;
    int       mw;
    request_t r;
    forever begin
      glyph_for_code(code, res, ms, mw);
      if (ms < 0 && mw < 0) break;
      r = scrambled_request();
      if (ms >= 0) begin
        r.kind  = REQ_SEG;
        r.index = 12'(ms);
      end else begin
        r.kind  = REQ_GLYPH;
        r.index = 12'(mw);
        if ($urandom_range(0, 3) == 0) r.word = 16'h0000;
      end
      send_request(r);
    end
    r = scrambled_request();
    r.kind = REQ_LOOKUP;
    r.code = code;
    send_request(r);
  endtask

  task automatic build_table(input int n);
    request_t r;
    int       span;
    int       st;
    int       len;
    int       pick;
    span = 65535 / n;
    for (int i = 0; i < n - 1; i++) begin
      r = scrambled_request();
      st = i * span + $urandom_range(0, span / 2);
      len = $urandom_range(0, (span / 2 < 48) ? span / 2 : 48);
      r.kind  = REQ_SEG;
      r.index = 12'(i);
      r.end_c = 16'(st + len);
      r.start_c = ($urandom_range(0, 15) == 0) ? 16'(st + len + 1) : 16'(st);
      pick = $urandom_range(0, 99);
      if (pick < 40) r.offset = 16'h0000;
      else if (pick < 85)
        r.offset = 16'(2 * ($urandom_range(0, WORD_DEPTH - 1 - len) - i + n)
                       + $urandom_range(0, 1));
      send_request(r);
    end
    r = scrambled_request();
    r.kind    = REQ_SEG;
    r.index   = 12'(n - 1);
    r.end_c   = 16'hFFFF;
    r.start_c = 16'hFFFF;
    r.delta   = 16'h0001;
    r.offset  = 16'h0000;
    send_request(r);
  endtask

  task automatic random_lookup();
    int n;
    int s;
    int lo;
    int hi;
    int pick;
    n = segments_in_use();
    pick = $urandom_range(0, 99);
    if (n >= 2 && pick < 75) begin
      s = $urandom_range(0, n - 2);
      lo = int'(start_mem[s]) - 1;
      hi = int'(end_mem[s]) + 1;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      lookup_code(16'($urandom_range(lo, hi)));
    end else if (n >= 2 && pick < 85) begin
      lookup_code(end_mem[$urandom_range(0, n - 1)]);
    end else begin
      lookup_code(16'($urandom));
    end
  endtask

  task automatic settle();
    in_req.valid <= 1'b0;
    while (glyph_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_segment_count(input logic [cmap4_pkg::CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seg_count = value;
    settings_seen++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (glyph_queue.size() == 0) begin
        $error("unexpected transaction: glyph_id %h mapped %b", out_res.glyph_id,
               out_res.mapped);
        mismatch_count++;
      end else begin
        want = glyph_queue.pop_front();
        if (out_res.glyph_id !== want.glyph_id) begin
          $error("glyph_id: expected %h, actual %h", want.glyph_id, out_res.glyph_id);
          mismatch_count++;
        end
        if (out_res.mapped !== want.mapped) begin
          $error("mapped: expected %b, actual %b", want.mapped, out_res.mapped);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    request_t r;
    int       n;
    int       phase_start;
    int       target;
    int       pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.req_type = REQ_NONE;
    in_req.entry_index = '0;
    in_req.end_code = '0;
    in_req.start_code = '0;
    in_req.id_delta = '0;
    in_req.range_offset = '0;
    in_req.glyph_word = '0;
    in_req.char_code = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        settle();
        write_segment_count(SCRIPT[i].cfg_value);
      end else begin
        send_request(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].res);
      end
    end

    for (int p = 0; p < 9; p++) begin
      settle();
      write_segment_count(PHASE_COUNTS[p]);
      send_idle_pct = (p < 3) ? 20 : (p < 6) ? 59 : 0;
      recv_idle_pct = (p < 3) ? 59 : (p < 6) ? 20 : 0;
      n = segments_in_use();
      if (n >= 2) build_table(n);
      phase_start = lookups_sent;
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target || lookups_sent - phase_start < PHASE_LOOKUPS) begin
        pick = $urandom_range(0, 99);
        r = scrambled_request();
        if (pick < 85) begin
          random_lookup();
        end else if (pick < 90) begin
          r.kind = REQ_NONE;
          send_request(r);
        end else if (pick < 95) begin
          r.kind = REQ_GLYPH;
          send_request(r);
        end else begin
          r.kind = REQ_SEG;
          r.index = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, SEG_DEPTH - 1))
                                                : 12'($urandom_range(SEG_DEPTH, 4095));
          send_request(r);
        end
      end
    end

    settle();
    $display("Sent %0d requests, %0d of them lookups with %0d mapped results,",
             sent_count, lookups_sent, mapped_seen);
    $display("across %0d segment-count settings under three idle patterns.", settings_seen);
    if (mismatch_count == 0 && glyph_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/cmap4_pkg.sv
sv/cmap4_req_if.sv
sv/cmap4_res_if.sv
sv/cmap4_store.sv
sv/cmap4_seq.sv
sv/cmap_format4_glyph_lookup.sv
verif/testbench.sv
